### sv/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types and constants for the trackball pulse accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpa_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // result field widths
    localparam int DELTA_W = 15;
    localparam int CLICK_W = 2;

    // delta saturation limits
    localparam int DELTA_MAX = 16383;
    localparam int DELTA_MIN = -16384;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] STEP_SCALE_RESET = 4'd8;
    localparam logic [CFG_DATA_W-1:0] ACCEL_KNEE_RESET = 4'd4;

    // number of direction pins, and the bit order of the sampled levels
    localparam int NUM_DIR   = 4;
    localparam int LVL_W     = 5;
    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;
    localparam int LVL_CLICK = 4;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SCALE = 2'd0,
        CFG_ACCEL_KNEE = 2'd1
    } t_cfg_index;

    // pending click codes, two's complement
    typedef enum logic [CLICK_W-1:0] {
        CLICK_NONE    = 2'b00,
        CLICK_PRESS   = 2'b01,
        CLICK_RELEASE = 2'b11
    } t_click;

endpackage

`default_nettype wire

### sv/tpa_accel_scale.sv
// ----------------------------------------------------------------------------
// tpa_accel_scale
// Applies the knee acceleration to a raw pulse difference, multiplies by the
// step scale and saturates to the signed delta range.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_accel_scale #(
    parameter int COUNT_BITS = 8
) (
    input  wire logic signed [COUNT_BITS:0]                 i_raw,
    input  wire logic        [tpa_pkg::CFG_DATA_W-1:0]      i_knee,
    input  wire logic        [tpa_pkg::CFG_DATA_W-1:0]      i_scale,
    output logic signed      [tpa_pkg::DELTA_W-1:0]         o_delta
);

    localparam int RAW_W = COUNT_BITS + 1;
    // three times the raw magnitude fits in two more bits
    localparam int ACC_W = RAW_W + 2;
    localparam int PRD_W = ACC_W + tpa_pkg::CFG_DATA_W + 1;
    localparam int CMP_W = (PRD_W > tpa_pkg::DELTA_W) ? PRD_W : tpa_pkg::DELTA_W;

    localparam logic signed [CMP_W-1:0] SAT_HI = CMP_W'(tpa_pkg::DELTA_MAX);
    localparam logic signed [CMP_W-1:0] SAT_LO = CMP_W'(tpa_pkg::DELTA_MIN);

    logic signed [ACC_W-1:0] raw_e;
    logic signed [ACC_W-1:0] knee_e;
    logic signed [ACC_W-1:0] acc;
    logic signed [PRD_W-1:0] prod;
    logic signed [CMP_W-1:0] prod_e;

    // extend operands
    assign raw_e  = {{2{i_raw[RAW_W-1]}}, i_raw};
    assign knee_e = {{(ACC_W - tpa_pkg::CFG_DATA_W){1'b0}}, i_knee};

    // excess beyond the knee is added twice more
    always_comb begin
        if (raw_e > knee_e) begin
            acc = raw_e + ((raw_e - knee_e) <<< 1);
        end else if (raw_e < -knee_e) begin
            acc = raw_e + ((raw_e + knee_e) <<< 1);
        end else begin
            acc = raw_e;
        end
    end

    // scale by the step
    assign prod = {{(tpa_pkg::CFG_DATA_W + 1){acc[ACC_W-1]}}, acc}
                * $signed({{(PRD_W - tpa_pkg::CFG_DATA_W){1'b0}}, i_scale});

    // saturate to the delta range
    assign prod_e = CMP_W'(prod);

    always_comb begin
        priority if (prod_e > SAT_HI) begin
            o_delta = SAT_HI[tpa_pkg::DELTA_W-1:0];
        end else if (prod_e < SAT_LO) begin
            o_delta = SAT_LO[tpa_pkg::DELTA_W-1:0];
        end else begin
            o_delta = prod_e[tpa_pkg::DELTA_W-1:0];
        end
    end

endmodule

`default_nettype wire

### sv/trackball_pulse_accumulator_unit.sv
// ----------------------------------------------------------------------------
// trackball_pulse_accumulator_unit
// Counts level changes on four trackball direction pins and the click pin,
// and on a poll reports accelerated, scaled motion and the pending click.
// ----------------------------------------------------------------------------
// Throughput: one sample beat per cycle while stage 1 is not held by a stalled report.
// A poll beat loads the raw difference register (stage 1) when it is accepted,
//   and the output register takes the accelerated, scaled result once it is free.
// Samples without poll update the accumulation state only and produce no result.
// Reset (synchronous, active low): counters and pending click cleared,
//   previous levels all ones, step scale 8, knee 4, pipeline empty.
`default_nettype none

module trackball_pulse_accumulator_unit #(
    parameter int COUNT_BITS = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // sample channel
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic                                   i_up_level,
    input  wire logic                                   i_down_level,
    input  wire logic                                   i_left_level,
    input  wire logic                                   i_right_level,
    input  wire logic                                   i_click_level,
    input  wire logic                                   i_poll,
    // report channel
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic signed [tpa_pkg::DELTA_W-1:0]          o_delta_x,
    output logic signed [tpa_pkg::DELTA_W-1:0]          o_delta_y,
    output logic signed [tpa_pkg::CLICK_W-1:0]          o_click_event,
    // configuration write channel
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [tpa_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [tpa_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int RAW_W = COUNT_BITS + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // configuration registers
    logic [tpa_pkg::CFG_DATA_W-1:0] r_step_scale;
    logic [tpa_pkg::CFG_DATA_W-1:0] r_accel_knee;

    // accumulation state
    logic [tpa_pkg::LVL_W-1:0]  r_prev_lvl;
    logic [COUNT_BITS-1:0]      r_cnt [tpa_pkg::NUM_DIR];
    logic [COUNT_BITS-1:0]      n_cnt [tpa_pkg::NUM_DIR];
    tpa_pkg::t_click            r_pend;
    tpa_pkg::t_click            n_pend;

    // stage 1: raw differences of a poll
    logic                       r_s1_valid;
    logic signed [RAW_W-1:0]    r_s1_raw_x;
    logic signed [RAW_W-1:0]    r_s1_raw_y;
    tpa_pkg::t_click            r_s1_click;

    // output register
    logic                                   r_out_valid;
    logic signed [tpa_pkg::DELTA_W-1:0]     r_out_dx;
    logic signed [tpa_pkg::DELTA_W-1:0]     r_out_dy;
    tpa_pkg::t_click                        r_out_click;

    logic                           in_acc;
    logic                           out_load;
    logic                           s1_adv;
    logic [tpa_pkg::LVL_W-1:0]      lvl;
    logic [tpa_pkg::LVL_W-1:0]      chg;
    logic signed [RAW_W-1:0]        n_raw_x;
    logic signed [RAW_W-1:0]        n_raw_y;
    logic signed [tpa_pkg::DELTA_W-1:0] acc_dx;
    logic signed [tpa_pkg::DELTA_W-1:0] acc_dy;

    // handshake and pipeline advance
    assign out_load    = !r_out_valid || i_ready;
    assign s1_adv      = r_s1_valid && out_load;
    assign o_ready     = !r_s1_valid || out_load;
    assign in_acc      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_scale <= tpa_pkg::STEP_SCALE_RESET;
            r_accel_knee <= tpa_pkg::ACCEL_KNEE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tpa_pkg::CFG_STEP_SCALE: r_step_scale <= i_cfg_data;
                tpa_pkg::CFG_ACCEL_KNEE: r_accel_knee <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // edge detection on the sampled levels
    assign lvl = {i_click_level, i_right_level, i_left_level, i_down_level, i_up_level};
    assign chg = lvl ^ r_prev_lvl;

    // saturating direction counters and latest click change
    always_comb begin
        for (int i = 0; i < tpa_pkg::NUM_DIR; i++) begin
            if (chg[i] && (r_cnt[i] != CNT_MAX)) begin
                n_cnt[i] = r_cnt[i] + COUNT_BITS'(1);
            end else begin
                n_cnt[i] = r_cnt[i];
            end
        end
        if (chg[tpa_pkg::LVL_CLICK]) begin
            n_pend = lvl[tpa_pkg::LVL_CLICK] ? tpa_pkg::CLICK_RELEASE
                                             : tpa_pkg::CLICK_PRESS;
        end else begin
            n_pend = r_pend;
        end
    end

    // raw motion from the counts including this beat's edges
    assign n_raw_x = $signed({1'b0, n_cnt[tpa_pkg::DIR_RIGHT]})
                   - $signed({1'b0, n_cnt[tpa_pkg::DIR_LEFT]});
    assign n_raw_y = $signed({1'b0, n_cnt[tpa_pkg::DIR_DOWN]})
                   - $signed({1'b0, n_cnt[tpa_pkg::DIR_UP]});

    // accumulation state update, poll clears after capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_lvl <= {tpa_pkg::LVL_W{1'b1}};
            r_pend     <= tpa_pkg::CLICK_NONE;
            for (int i = 0; i < tpa_pkg::NUM_DIR; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (in_acc) begin
            r_prev_lvl <= lvl;
            if (i_poll) begin
                r_pend <= tpa_pkg::CLICK_NONE;
                for (int i = 0; i < tpa_pkg::NUM_DIR; i++) begin
                    r_cnt[i] <= '0;
                end
            end else begin
                r_pend <= n_pend;
                for (int i = 0; i < tpa_pkg::NUM_DIR; i++) begin
                    r_cnt[i] <= n_cnt[i];
                end
            end
        end
    end

    // stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc && i_poll) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_acc && i_poll) begin
            r_s1_raw_x <= n_raw_x;
            r_s1_raw_y <= n_raw_y;
            r_s1_click <= n_pend;
        end
    end

    // acceleration and scaling per axis
    tpa_accel_scale #(
        .COUNT_BITS (COUNT_BITS)
    ) u_accel_x (
        .i_raw   (r_s1_raw_x),
        .i_knee  (r_accel_knee),
        .i_scale (r_step_scale),
        .o_delta (acc_dx)
    );

    tpa_accel_scale #(
        .COUNT_BITS (COUNT_BITS)
    ) u_accel_y (
        .i_raw   (r_s1_raw_y),
        .i_knee  (r_accel_knee),
        .i_scale (r_step_scale),
        .o_delta (acc_dy)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_dx    <= acc_dx;
            r_out_dy    <= acc_dy;
            r_out_click <= r_s1_click;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_delta_x     = r_out_dx;
    assign o_delta_y     = r_out_dy;
    assign o_click_event = r_out_click;

    // a poll beat always reaches stage 1
    a_poll_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_poll) |=> r_s1_valid)
        else $error("poll beat did not load stage 1");

    // a poll leaves counters and pending click cleared
    a_poll_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_poll) |=> ((r_cnt[tpa_pkg::DIR_UP] == '0)
                             && (r_cnt[tpa_pkg::DIR_DOWN] == '0)
                             && (r_cnt[tpa_pkg::DIR_LEFT] == '0)
                             && (r_cnt[tpa_pkg::DIR_RIGHT] == '0)
                             && (r_pend == tpa_pkg::CLICK_NONE)))
        else $error("poll did not clear accumulation state");

    // stage 1 never overwritten while it waits on a stalled output
    a_s1_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_load) |-> !in_acc)
        else $error("stage 1 overrun");

    // a stalled report does not drain stage 1
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && r_s1_valid) |=> (r_out_valid && r_s1_valid))
        else $error("stalled report lost");

endmodule

`default_nettype wire

### tb/tpa_report_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpa_report_checker
// Watches the sample, report and register channels of the trackball pulse
// accumulator, keeps its own copy of the counters, pending click and
// settings, and compares every report beat with the oldest predicted one.
// ----------------------------------------------------------------------------

module tpa_report_checker #(
    parameter int COUNT_BITS = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // sample channel
    input  wire logic                                   i_smp_valid,
    input  wire logic                                   i_smp_ready,
    input  wire logic                                   i_up_level,
    input  wire logic                                   i_down_level,
    input  wire logic                                   i_left_level,
    input  wire logic                                   i_right_level,
    input  wire logic                                   i_click_level,
    input  wire logic                                   i_poll,
    // report channel
    input  wire logic                                   i_rpt_valid,
    input  wire logic                                   i_rpt_ready,
    input  wire logic signed [tpa_pkg::DELTA_W-1:0]     i_delta_x,
    input  wire logic signed [tpa_pkg::DELTA_W-1:0]     i_delta_y,
    input  wire logic signed [tpa_pkg::CLICK_W-1:0]     i_click_event,
    // register write channel
    input  wire logic                                   i_cfg_valid,
    input  wire logic                                   i_cfg_ready,
    input  wire logic [tpa_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [tpa_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // status towards the testbench top
    output int unsigned                                 o_outstanding,
    output int unsigned                                 o_errors
);

    import tpa_pkg::*;

    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        t_click                    click;
    } t_motion_report;

    t_motion_report             report_q[$];
    logic [LVL_W-1:0]           last_lv;
    logic [COUNT_BITS-1:0]      edge_cnt [NUM_DIR];
    t_click                     held_click;
    logic [CFG_DATA_W-1:0]      step_scale;
    logic [CFG_DATA_W-1:0]      accel_knee;
    int unsigned                error_count;

    assign o_errors = error_count;

    // one line per mismatch, and count it
    task automatic log_error(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // extra gain of two on the part of the count beyond the knee
    function automatic int boost(input int raw, input int knee);
        int a;
        a = raw;
        if (raw > knee)
            a += 2 * (raw - knee);
        if (raw < -knee)
            a += 2 * (raw + knee);
        return a;
    endfunction

    // scale by the step and clamp to the delta field
    function automatic logic signed [DELTA_W-1:0] to_delta(input int a);
        int v;
        v = a * int'(step_scale);
        if (v > DELTA_MAX)
            v = DELTA_MAX;
        if (v < DELTA_MIN)
            v = DELTA_MIN;
        return v[DELTA_W-1:0];
    endfunction

    // count edges of one sample beat, then serve a poll
    task automatic take_sample();
        logic [LVL_W-1:0] lv;
        logic [LVL_W-1:0] flips;
        t_motion_report   rep;
        int               raw_x;
        int               raw_y;
        lv[DIR_UP]    = i_up_level;
        lv[DIR_DOWN]  = i_down_level;
        lv[DIR_LEFT]  = i_left_level;
        lv[DIR_RIGHT] = i_right_level;
        lv[LVL_CLICK] = i_click_level;
        flips = lv ^ last_lv;
        for (int d = 0; d < NUM_DIR; d++)
            if (flips[d] && edge_cnt[d] != '1)
                edge_cnt[d] = edge_cnt[d] + 1'b1;
        // latest click change wins
        if (flips[LVL_CLICK])
            held_click = lv[LVL_CLICK] ? CLICK_RELEASE : CLICK_PRESS;
        last_lv = lv;
        if (i_poll) begin
            raw_x = int'(edge_cnt[DIR_RIGHT]) - int'(edge_cnt[DIR_LEFT]);
            raw_y = int'(edge_cnt[DIR_DOWN]) - int'(edge_cnt[DIR_UP]);
            rep.dx    = to_delta(boost(raw_x, int'(accel_knee)));
            rep.dy    = to_delta(boost(raw_y, int'(accel_knee)));
            rep.click = held_click;
            report_q.push_back(rep);
            for (int d = 0; d < NUM_DIR; d++)
                edge_cnt[d] = '0;
            held_click = CLICK_NONE;
        end
    endtask

    // compare a report beat with the oldest prediction
    task automatic take_report();
        t_motion_report want;
        if (report_q.size() == 0) begin
            log_error($sformatf("unexpected report dx %0d dy %0d click %0d",
                                i_delta_x, i_delta_y, i_click_event));
        end else begin
            want = report_q.pop_front();
            if (i_delta_x !== want.dx)
                log_error($sformatf("delta_x got %0d want %0d", i_delta_x, want.dx));
            if (i_delta_y !== want.dy)
                log_error($sformatf("delta_y got %0d want %0d", i_delta_y, want.dy));
            if (i_click_event !== want.click)
                log_error($sformatf("click_event got %0d want %0d",
                                    i_click_event, $signed(want.click)));
        end
    endtask

    // channel monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            report_q.delete();
            last_lv    = '1;
            for (int d = 0; d < NUM_DIR; d++)
                edge_cnt[d] = '0;
            held_click = CLICK_NONE;
            step_scale = STEP_SCALE_RESET;
            accel_knee = ACCEL_KNEE_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STEP_SCALE: step_scale = i_cfg_data;
                    CFG_ACCEL_KNEE: accel_knee = i_cfg_data;
                    default: ;
                endcase
            end
            // a report beat always belongs to an earlier poll
            if (i_rpt_valid && i_rpt_ready)
                take_report();
            if (i_smp_valid && i_smp_ready)
                take_sample();
        end
        o_outstanding <= report_q.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pin samples, polls and register writes into the trackball pulse
// accumulator with random idle gaps on both channels; the checker beside the
// block predicts every motion report and counts mismatches.
// ----------------------------------------------------------------------------

module tb_top;

    import tpa_pkg::*;

    localparam int COUNT_BITS   = 8;
    localparam int PHASE_BEATS  = 155;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 300000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;
    localparam logic [LVL_W-1:0]     LVL_IDLE      = '1;
    localparam logic [LVL_W-1:0]     M_UP          = LVL_W'(1) << DIR_UP;
    localparam logic [LVL_W-1:0]     M_DOWN        = LVL_W'(1) << DIR_DOWN;
    localparam logic [LVL_W-1:0]     M_LEFT        = LVL_W'(1) << DIR_LEFT;
    localparam logic [LVL_W-1:0]     M_RIGHT       = LVL_W'(1) << DIR_RIGHT;
    localparam logic [LVL_W-1:0]     M_CLICK       = LVL_W'(1) << LVL_CLICK;

    logic                           clk;
    logic                           rst_n;
    logic                           smp_valid;
    logic                           smp_ready;
    logic [LVL_W-1:0]               smp_pins;
    logic                           smp_poll;
    logic                           rpt_valid;
    logic                           rpt_ready;
    logic signed [DELTA_W-1:0]      delta_x;
    logic signed [DELTA_W-1:0]      delta_y;
    logic signed [CLICK_W-1:0]      click_event;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [CFG_IDX_W-1:0]           cfg_index;
    logic [CFG_DATA_W-1:0]          cfg_data;
    int unsigned                    outstanding;
    int unsigned                    errors;
    int                             cycles = 0;
    logic [LVL_W-1:0]               pins;
    int                             calm_tx;
    int                             calm_rx;

    trackball_pulse_accumulator_unit #(
        .COUNT_BITS(COUNT_BITS)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (smp_valid),
        .o_ready        (smp_ready),
        .i_up_level     (smp_pins[DIR_UP]),
        .i_down_level   (smp_pins[DIR_DOWN]),
        .i_left_level   (smp_pins[DIR_LEFT]),
        .i_right_level  (smp_pins[DIR_RIGHT]),
        .i_click_level  (smp_pins[LVL_CLICK]),
        .i_poll         (smp_poll),
        .o_valid        (rpt_valid),
        .i_ready        (rpt_ready),
        .o_delta_x      (delta_x),
        .o_delta_y      (delta_y),
        .o_click_event  (click_event),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    tpa_report_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_smp_valid    (smp_valid),
        .i_smp_ready    (smp_ready),
        .i_up_level     (smp_pins[DIR_UP]),
        .i_down_level   (smp_pins[DIR_DOWN]),
        .i_left_level   (smp_pins[DIR_LEFT]),
        .i_right_level  (smp_pins[DIR_RIGHT]),
        .i_click_level  (smp_pins[LVL_CLICK]),
        .i_poll         (smp_poll),
        .i_rpt_valid    (rpt_valid),
        .i_rpt_ready    (rpt_ready),
        .i_delta_x      (delta_x),
        .i_delta_y      (delta_y),
        .i_click_event  (click_event),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_outstanding  (outstanding),
        .o_errors       (errors)
    );

    // 20 ns clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // idle gap per beat, with occasional stretches of back-to-back beats
    task automatic pick_gap(inout int calm, output int gap);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(8, 40);
            gap  = 0;
        end else begin
            gap = $urandom_range(0, 17);
        end
    endtask

    // one sample beat, held until accepted
    task automatic send_sample(input logic [LVL_W-1:0] lv, input logic poll_req);
        int gap;
        pick_gap(calm_tx, gap);
        repeat (gap) begin
            @(negedge clk);
            smp_valid <= 1'b0;
        end
        @(negedge clk);
        smp_valid <= 1'b1;
        smp_pins  <= lv;
        smp_poll  <= poll_req;
        do @(posedge clk); while (!smp_ready);
        pins = lv;
    endtask

    // wait until every report is back and the pipeline has drained
    task automatic settle();
        @(negedge clk);
        smp_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // motion burst closed by a poll: heading pins toggle often,
    // flood pins toggle on every beat
    task automatic send_run(input int len, input logic [NUM_DIR-1:0] heading,
                            input logic [NUM_DIR-1:0] flood);
        logic [LVL_W-1:0] flip;
        for (int k = 0; k <= len; k++) begin
            flip = '0;
            for (int d = 0; d < NUM_DIR; d++)
                if (flood[d] || (heading[d] ? $urandom_range(0, 3) != 0
                                            : $urandom_range(0, 7) == 0))
                    flip[d] = 1'b1;
            flip[LVL_CLICK] = ($urandom_range(0, 9) == 0);
            send_sample(pins ^ flip, k == len);
        end
    endtask

    // fully random levels, polls at random
    task automatic send_noise(input int len);
        for (int k = 0; k < len; k++)
            send_sample(LVL_W'($urandom_range(0, 31)), $urandom_range(0, 3) == 0);
    endtask

    // random traffic for one register setting
    task automatic run_phase(input bit with_flood);
        int done;
        int len;
        done = 0;
        // long single-pin run drives a counter into saturation
        if (with_flood)
            send_run($urandom_range(256, 300), '0,
                     NUM_DIR'(1) << $urandom_range(0, NUM_DIR - 1));
        while (done < PHASE_BEATS) begin
            len = $urandom_range(0, 20);
            if ($urandom_range(0, 7) == 0)
                send_noise(len + 1);
            else
                send_run(len, NUM_DIR'($urandom_range(1, 15)), '0);
            done += len + 1;
        end
    endtask

    // report side ready with random stalls
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            pick_gap(calm_rx, gap);
            repeat (gap) begin
                @(negedge clk);
                rpt_ready <= 1'b0;
            end
            @(negedge clk);
            rpt_ready <= 1'b1;
            do @(posedge clk); while (!rpt_valid);
        end
    end

    // stimulus and verdict
    initial begin
        logic [LVL_W-1:0] flip;
        rst_n     = 1'b0;
        smp_valid = 1'b0;
        smp_pins  = LVL_IDLE;
        smp_poll  = 1'b0;
        rpt_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STEP_SCALE;
        cfg_data  = '0;
        pins      = LVL_IDLE;
        calm_tx   = 0;
        calm_rx   = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed opening at reset settings
        send_sample(LVL_IDLE, 1'b1);        // poll without motion
        send_sample('0, 1'b0);              // every pin falls, press pending
        send_sample(LVL_IDLE, 1'b1);        // every pin rises, release replaces it
        // right past the knee, down below it, press then release
        for (int k = 0; k < 6; k++) begin
            flip = M_RIGHT;
            if (k < 3)
                flip |= M_DOWN;
            if (k == 1 || k == 2)
                flip |= M_CLICK;
            send_sample(pins ^ flip, k == 5);
        end
        // left and up past the knee, press on the polling beat itself
        for (int k = 0; k < 7; k++) begin
            flip = M_LEFT;
            if (k < 6)
                flip |= M_UP;
            if (k == 6)
                flip |= M_CLICK;
            send_sample(pins ^ flip, k == 6);
        end
        send_sample(~pins, 1'b1);           // edges on every pin counted before the poll

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_reg(CFG_STEP_SCALE, 4'd0);
                    write_reg(CFG_ACCEL_KNEE, 4'd15);
                end
                1: begin
                    write_reg(CFG_STEP_SCALE, 4'd15);
                    write_reg(CFG_ACCEL_KNEE, 4'd0);
                end
                2: begin
                    write_reg(CFG_STEP_SCALE, 4'd1);
                    write_reg(CFG_ACCEL_KNEE, 4'd15);
                end
                3: begin
                    write_reg(CFG_STEP_SCALE, 4'd15);
                    write_reg(CFG_ACCEL_KNEE, 4'd15);
                end
                4: begin
                    // unused index must leave both registers alone
                    write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom_range(0, 15)));
                    write_reg(CFG_STEP_SCALE, 4'd3);
                    write_reg(CFG_ACCEL_KNEE, 4'd2);
                end
                default: begin
                    write_reg(CFG_STEP_SCALE, CFG_DATA_W'($urandom_range(0, 15)));
                    write_reg(CFG_ACCEL_KNEE, CFG_DATA_W'($urandom_range(0, 15)));
                end
            endcase
            run_phase(ph == 1 || ph == 3);
        end

        settle();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/tpa_pkg.sv
sv/tpa_accel_scale.sv
sv/trackball_pulse_accumulator_unit.sv
tb/tpa_report_checker.sv
tb/tb_top.sv
